FILE: src/lct_pkg.sv
`default_nettype none

package lct_pkg;

    localparam int unsigned KEY_W   = 32;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned COUNT_W = 32;
    localparam int unsigned TIME_W  = 64;
    localparam int unsigned CAP_W   = 5;

    localparam logic [CAP_W-1:0]   CAPACITY_RESET = 5'd2;
    localparam logic [COUNT_W-1:0] COUNT_MAX      = 32'hFFFF_FFFF;
    localparam logic [COUNT_W-1:0] COUNT_FIRST    = 32'd1;
    localparam logic [VALUE_W-1:0] READ_MISS      = 32'hFFFF_FFFF;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] count;
        logic [TIME_W-1:0]  stamp;
    } entry_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_UPDATE
    } state_t;

    typedef struct packed {
        logic load;
        logic rd_en;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic addr_last;
        logic out_free;
    } ctrl_sts_t;

endpackage

`default_nettype wire

FILE: src/lct_ram.sv
`default_nettype none

module lct_ram #(
    parameter int unsigned WIDTH = 160,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: src/lct_ctrl.sv
`default_nettype none

module lct_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire lct_pkg::ctrl_sts_t sts,
    output lct_pkg::ctrl_cmd_t     cmd
);

    lct_pkg::state_t state_reg;
    lct_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lct_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            lct_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = lct_pkg::S_SCAN;
                end
            end
            lct_pkg::S_SCAN:
            begin
                cmd.rd_en = 1'b1;
                if (sts.addr_last)
                begin
                    state_next = lct_pkg::S_LAST;
                end
            end
            lct_pkg::S_LAST:
            begin
                state_next = lct_pkg::S_UPDATE;
            end
            lct_pkg::S_UPDATE:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = lct_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = lct_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: src/lct_datapath.sv
`default_nettype none

module lct_datapath #(
    parameter int unsigned MAX_ENTRIES = 16,
    localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
    localparam int unsigned CW = $clog2(MAX_ENTRIES + 1)
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [lct_pkg::CAP_W-1:0]   cfg_wdata,
    input  wire logic                        in_cmd,
    input  wire logic [lct_pkg::KEY_W-1:0]   in_key,
    input  wire logic [lct_pkg::VALUE_W-1:0] in_value,
    input  wire lct_pkg::ctrl_cmd_t          cmd,
    output lct_pkg::ctrl_sts_t               sts,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic                             out_found,
    output logic [lct_pkg::VALUE_W-1:0]      out_read_value,
    output logic                             out_evicted,
    output logic [lct_pkg::KEY_W-1:0]        out_evicted_key
);

    logic [lct_pkg::CAP_W-1:0] capacity_reg;
    logic [MAX_ENTRIES-1:0]    valid_reg;
    logic [CW-1:0]             used_reg;
    logic [lct_pkg::TIME_W-1:0] time_reg;

    logic                         req_cmd_reg;
    logic [lct_pkg::KEY_W-1:0]    req_key_reg;
    logic [lct_pkg::VALUE_W-1:0]  req_value_reg;

    logic [IW-1:0] addr_reg;
    logic          proc_vld_reg;
    logic [IW-1:0] proc_idx_reg;

    logic                         hit_reg;
    logic [IW-1:0]                hit_idx_reg;
    logic [lct_pkg::VALUE_W-1:0]  hit_value_reg;
    logic [lct_pkg::COUNT_W-1:0]  hit_count_reg;

    logic                         vic_found_reg;
    logic [IW-1:0]                vic_idx_reg;
    logic [lct_pkg::COUNT_W-1:0]  vic_count_reg;
    logic [lct_pkg::TIME_W-1:0]   vic_time_reg;
    logic [lct_pkg::KEY_W-1:0]    vic_key_reg;

    logic          free_found_reg;
    logic [IW-1:0] free_idx_reg;

    logic                         out_valid_reg;
    logic                         out_found_reg;
    logic [lct_pkg::VALUE_W-1:0]  out_read_value_reg;
    logic                         out_evicted_reg;
    logic [lct_pkg::KEY_W-1:0]    out_evicted_key_reg;

    logic [$bits(lct_pkg::entry_t)-1:0] rd_raw;
    lct_pkg::entry_t                    rd_entry;
    logic                               rd_valid;
    logic                               is_hit;
    logic                               is_better;

    logic [CW-1:0]              cap_eff;
    logic [lct_pkg::TIME_W-1:0] time_next;
    logic [lct_pkg::COUNT_W-1:0] count_inc;
    logic                       wr;
    logic [IW-1:0]              wr_idx;
    lct_pkg::entry_t            wr_entry;
    logic                       inc_used;
    logic                       o_found;
    logic [lct_pkg::VALUE_W-1:0] o_read_value;
    logic                       o_evicted;
    logic [lct_pkg::KEY_W-1:0]  o_evicted_key;

    lct_ram #(
        .WIDTH ($bits(lct_pkg::entry_t)),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.commit & wr),
        .waddr (wr_idx),
        .wdata (wr_entry),
        .re    (cmd.rd_en),
        .raddr (addr_reg),
        .rdata (rd_raw)
    );

    assign rd_entry  = lct_pkg::entry_t'(rd_raw);
    assign rd_valid  = proc_vld_reg & valid_reg[proc_idx_reg];
    assign is_hit    = rd_valid & (rd_entry.key == req_key_reg);
    assign is_better = rd_valid & (!vic_found_reg || (rd_entry.count < vic_count_reg) ||
                       ((rd_entry.count == vic_count_reg) && (rd_entry.stamp < vic_time_reg)));

    assign sts.addr_last = (addr_reg == IW'(MAX_ENTRIES - 1));
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign cap_eff   = ({27'd0, capacity_reg} > 32'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES)
                                                                 : CW'(capacity_reg);
    assign time_next = time_reg + 64'd1;
    assign count_inc = (hit_count_reg == lct_pkg::COUNT_MAX) ? hit_count_reg
                                                             : hit_count_reg + 32'd1;

    always_comb
    begin
        wr             = 1'b0;
        wr_idx         = hit_idx_reg;
        wr_entry.key   = req_key_reg;
        wr_entry.value = req_value_reg;
        wr_entry.count = count_inc;
        wr_entry.stamp = time_next;
        inc_used       = 1'b0;
        o_found        = hit_reg;
        o_read_value   = '0;
        o_evicted      = 1'b0;
        o_evicted_key  = '0;
        if (req_cmd_reg == lct_pkg::CMD_GET)
        begin
            if (hit_reg)
            begin
                wr             = 1'b1;
                wr_entry.value = hit_value_reg;
                o_read_value   = hit_value_reg;
            end
            else
            begin
                o_read_value = lct_pkg::READ_MISS;
            end
        end
        else if (cap_eff != '0)
        begin
            if (hit_reg)
            begin
                wr = 1'b1;
            end
            else if (used_reg >= cap_eff)
            begin
                if (vic_found_reg)
                begin
                    wr             = 1'b1;
                    wr_idx         = vic_idx_reg;
                    wr_entry.count = lct_pkg::COUNT_FIRST;
                    o_evicted      = 1'b1;
                    o_evicted_key  = vic_key_reg;
                end
            end
            else if (free_found_reg)
            begin
                wr             = 1'b1;
                wr_idx         = free_idx_reg;
                wr_entry.count = lct_pkg::COUNT_FIRST;
                inc_used       = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg   <= lct_pkg::CAPACITY_RESET;
            valid_reg      <= '0;
            used_reg       <= '0;
            time_reg       <= '0;
            proc_vld_reg   <= 1'b0;
            hit_reg        <= 1'b0;
            vic_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                capacity_reg <= cfg_wdata;
            end
            proc_vld_reg <= cmd.rd_en;
            if (cmd.load)
            begin
                hit_reg        <= 1'b0;
                vic_found_reg  <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else
            begin
                if (is_hit && !hit_reg)
                begin
                    hit_reg <= 1'b1;
                end
                if (is_better)
                begin
                    vic_found_reg <= 1'b1;
                end
                if (proc_vld_reg && !valid_reg[proc_idx_reg] && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                end
            end
            if (cmd.commit)
            begin
                if (wr)
                begin
                    time_reg          <= time_next;
                    valid_reg[wr_idx] <= 1'b1;
                end
                if (inc_used)
                begin
                    used_reg <= used_reg + CW'(1);
                end
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_cmd_reg   <= in_cmd;
            req_key_reg   <= in_key;
            req_value_reg <= in_value;
            addr_reg      <= '0;
        end
        else if (cmd.rd_en)
        begin
            addr_reg <= addr_reg + IW'(1);
        end
        proc_idx_reg <= addr_reg;
        if (is_hit && !hit_reg)
        begin
            hit_idx_reg   <= proc_idx_reg;
            hit_value_reg <= rd_entry.value;
            hit_count_reg <= rd_entry.count;
        end
        if (is_better)
        begin
            vic_idx_reg   <= proc_idx_reg;
            vic_count_reg <= rd_entry.count;
            vic_time_reg  <= rd_entry.stamp;
            vic_key_reg   <= rd_entry.key;
        end
        if (proc_vld_reg && !valid_reg[proc_idx_reg] && !free_found_reg)
        begin
            free_idx_reg <= proc_idx_reg;
        end
        if (cmd.commit)
        begin
            out_found_reg       <= o_found;
            out_read_value_reg  <= o_read_value;
            out_evicted_reg     <= o_evicted;
            out_evicted_key_reg <= o_evicted_key;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_found       = out_found_reg;
    assign out_read_value  = out_read_value_reg;
    assign out_evicted     = out_evicted_reg;
    assign out_evicted_key = out_evicted_key_reg;

endmodule

`default_nettype wire

FILE: src/lfu_cache_table_core.sv
// A request is taken only when idle; the controller then scans every table entry
// once through the single read port of the entry RAM, handles the last read and
// commits the result when the output register is free, then takes the next one.
// A finished result waits in the output register while the next request is taken.
// Reset (rst_n, async, active low): table empty, timestamp 0, capacity 2.
`default_nettype none

module lfu_cache_table_core #(
    parameter int unsigned MAX_ENTRIES = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [4:0]  cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // key[31:0], value[63:32]
    input  wire logic        s_tuser,   // cmd
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // read_value[31:0], evicted_key[63:32]
    output logic [1:0]       m_tuser    // found[0], evicted[1]
);

    lct_pkg::ctrl_cmd_t cmd;
    lct_pkg::ctrl_sts_t sts;

    logic        found;
    logic [31:0] read_value;
    logic        evicted;
    logic [31:0] evicted_key;

    lct_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lct_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .in_cmd          (s_tuser),
        .in_key          (s_tdata[31:0]),
        .in_value        (s_tdata[63:32]),
        .cmd             (cmd),
        .sts             (sts),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_found       (found),
        .out_read_value  (read_value),
        .out_evicted     (evicted),
        .out_evicted_key (evicted_key)
    );

    assign m_tdata = {evicted_key, read_value};
    assign m_tuser = {evicted, found};

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while a request is in progress");

    a_commit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> sts.out_free)
        else $error("result committed over an untaken result");

    a_evict_implies_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> (!m_tuser[0] && (m_tdata[31:0] == 32'd0)))
        else $error("eviction reported on a hit or with nonzero read value");
`endif

endmodule

`default_nettype wire
